// ===== sv/wclp_pkg.sv =====
// Shared constants, types and helper functions for the command line parser.
package wclp_pkg;

  localparam int LINE_MAX    = 48;
  localparam int MAX_CLIENTS = 5;
  localparam int CNT_W       = $clog2(LINE_MAX);
  localparam int MASK_W      = 5;
  localparam int HEAD_N      = 5;
  localparam int KIND_W      = 4;
  localparam int VALUE_W     = 32;
  localparam int INT_W       = 15;
  localparam int FRAC_W      = 14;
  localparam int FRAC_BITS   = 16;
  localparam int POS_W       = 2;
  localparam int DIG_W       = 3;

  localparam logic [INT_W-1:0] INT_SAT = 15'd32767;

  // fraction scaling: q = floor((f4*4096 + 312) / 625) via reciprocal and one correction
  localparam int Z_W       = FRAC_W + 12;
  localparam int RECIP_W   = 23;
  localparam int RECIP_SH  = 32;
  localparam int PROD_W    = Z_W + RECIP_W;
  localparam logic [Z_W-1:0]     Z_BIAS = 26'd312;
  localparam logic [RECIP_W-1:0] RECIP  = 23'd6871947;
  localparam logic [Z_W-1:0]     DIVISOR = 26'd625;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 4'd0,
    KIND_SPEED    = 4'd1,
    KIND_TURN     = 4'd2,
    KIND_ANGLE    = 4'd3,
    KIND_STOP     = 4'd4,
    KIND_ANGLE_KP = 4'd5,
    KIND_ANGLE_KD = 4'd6,
    KIND_SPEED_KP = 4'd7,
    KIND_SPEED_KI = 4'd8,
    KIND_TURN_KP  = 4'd9,
    KIND_TURN_KD  = 4'd10
  } kind_t;

  typedef enum logic [3:0] {
    PH_BLANK = 4'b0001,
    PH_INT   = 4'b0010,
    PH_FRAC  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic              neg;
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac4;
    logic [MASK_W-1:0] mask;
  } line_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic num_start(input logic [7:0] c);
    return is_digit(c) || (c == "-") || (c == "+") || (c == ".");
  endfunction

  function automatic logic [FRAC_W-1:0] frac_weight(input logic [DIG_W-1:0] n,
                                                   input logic [3:0] d);
    logic [FRAC_W-1:0] dd;
    dd = FRAC_W'(d);
    case (n)
      3'd0:    return FRAC_W'(dd * 14'd1000);
      3'd1:    return FRAC_W'(dd * 14'd100);
      3'd2:    return FRAC_W'(dd * 14'd10);
      3'd3:    return dd;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== sv/wifi_command_line_parser_top.sv =====
// Top level of the command line parser: byte parser and fixed-point output stage.
//
// Input channel: one received character per word on in_rx_byte, valid/ready.
// CR is dropped, a zero byte ends the line text, characters past LINE_MAX-1 are
// dropped, and LF closes the line and yields exactly one output word.
// Output channel: out_cmd_kind, out_value (signed Q15.16) and out_client_mask,
// valid/ready, one word per LF.
// Throughput: one byte per cycle, LF included, as long as out_ready keeps up.
// Path of an accepted LF to its output word: byte register, line result register,
// reciprocal multiply register, output register; the fraction scaling multiply sets
// the extra stage.
// Reset (rst_n low, synchronous): line state, client mask and all valid bits clear.
// When the receiver stalls, up to three finished words sit in the pipeline and
// non-LF bytes keep being taken; in_ready drops only when an LF finds every stage full.
module wifi_command_line_parser_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wclp_pkg::KIND_W-1:0]         out_cmd_kind,
  output logic signed [wclp_pkg::VALUE_W-1:0] out_value,
  output logic [wclp_pkg::MASK_W-1:0]         out_client_mask
);
  import wclp_pkg::*;

  logic      res_valid;
  logic      res_ready;
  line_res_t res;

  wclp_line_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  wclp_fixed_out u_fixed (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cmd_kind    (out_cmd_kind),
    .out_value       (out_value),
    .out_client_mask (out_client_mask)
  );

endmodule

// ===== sv/wclp_line_parse.sv =====
// Byte input register, per-line parse state and the per-line result register.
module wclp_line_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 res_valid,
  input  logic                 res_ready,
  output wclp_pkg::line_res_t  res
);
  import wclp_pkg::*;

  logic                 byte_v_r, byte_v_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 res_v_r, res_v_nxt;
  line_res_t            res_r, res_nxt;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ended_r, ended_nxt;
  logic [7:0]           head_r [HEAD_N];
  logic [7:0]           head_nxt [HEAD_N];
  logic                 colon_r, colon_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [7:0]           lead0_r, lead0_nxt, lead1_r, lead1_nxt;
  phase_t               phase_r, phase_nxt;
  logic                 neg_r, neg_nxt;
  logic [INT_W-1:0]     int_r, int_nxt;
  logic [FRAC_W-1:0]    frac_r, frac_nxt;
  logic [DIG_W-1:0]     dig_r, dig_nxt;
  logic [MASK_W-1:0]    mask_r, mask_nxt;

  logic                 is_lf;
  logic                 res_free;
  logic                 byte_take;

  assign is_lf     = (byte_r == CH_LF);
  assign res_free  = !res_v_r || res_ready;
  assign byte_take = byte_v_r && (!is_lf || res_free);
  assign in_ready  = !byte_v_r || byte_take;
  assign res_valid = res_v_r;
  assign res       = res_r;

  always_comb begin
    logic [7:0]        c;
    logic [3:0]        d;
    logic [7:0]        p0;
    logic              feed;
    logic [18:0]       int_wide;
    logic [3:0]        cid;
    kind_t             kind;
    logic [MASK_W-1:0] m;
    c        = byte_r;
    d        = byte_r[3:0];
    p0       = lead0_r;
    feed     = 1'b0;
    int_wide = '0;
    cid      = head_r[0][3:0];
    kind     = KIND_NONE;
    m        = mask_r;

    byte_v_nxt = byte_v_r;
    byte_nxt   = byte_r;
    res_v_nxt  = res_v_r && !res_ready;
    res_nxt    = res_r;
    count_nxt  = count_r;
    ended_nxt  = ended_r;
    for (int i = 0; i < HEAD_N; i++) head_nxt[i] = head_r[i];
    colon_nxt  = colon_r;
    pos_nxt    = pos_r;
    lead0_nxt  = lead0_r;
    lead1_nxt  = lead1_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    int_nxt    = int_r;
    frac_nxt   = frac_r;
    dig_nxt    = dig_r;
    mask_nxt   = mask_r;

    if (byte_take) byte_v_nxt = 1'b0;
    if (in_valid && in_ready) begin
      byte_v_nxt = 1'b1;
      byte_nxt   = in_rx_byte;
    end

    if (byte_take) begin
      if (is_lf) begin
        // connect / close events keyed on "d,CON" and "d,CL"
        if (is_digit(head_r[0]) && head_r[1] == "," && cid < 4'(MAX_CLIENTS)
            && cid < 4'(MASK_W)) begin
          if (head_r[2] == "C" && head_r[3] == "O" && head_r[4] == "N")
            m[cid[2:0]] = 1'b1;
          else if (head_r[2] == "C" && head_r[3] == "L")
            m[cid[2:0]] = 1'b0;
        end
        mask_nxt = m;
        case (lead0_r)
          "S":     kind = num_start(lead1_r) ? KIND_SPEED : KIND_NONE;
          "T":     kind = num_start(lead1_r) ? KIND_TURN : KIND_NONE;
          "A":     kind = num_start(lead1_r) ? KIND_ANGLE : KIND_NONE;
          "Z":     kind = KIND_STOP;
          "a":     kind = (lead1_r == "p") ? KIND_ANGLE_KP :
                          (lead1_r == "d") ? KIND_ANGLE_KD : KIND_NONE;
          "s":     kind = (lead1_r == "p") ? KIND_SPEED_KP :
                          (lead1_r == "i") ? KIND_SPEED_KI : KIND_NONE;
          "t":     kind = (lead1_r == "p") ? KIND_TURN_KP :
                          (lead1_r == "d") ? KIND_TURN_KD : KIND_NONE;
          default: kind = KIND_NONE;
        endcase
        res_nxt.kind = kind;
        res_nxt.mask = m;
        if (kind == KIND_NONE || kind == KIND_STOP) begin
          res_nxt.neg      = 1'b0;
          res_nxt.int_part = '0;
          res_nxt.frac4    = '0;
        end else begin
          res_nxt.neg      = neg_r;
          res_nxt.int_part = int_r;
          res_nxt.frac4    = frac_r;
        end
        res_v_nxt = 1'b1;
        count_nxt = '0;
        ended_nxt = 1'b0;
        for (int i = 0; i < HEAD_N; i++) head_nxt[i] = '0;
        colon_nxt = 1'b0;
        pos_nxt   = '0;
        lead0_nxt = '0;
        lead1_nxt = '0;
        phase_nxt = PH_BLANK;
        neg_nxt   = 1'b0;
        int_nxt   = '0;
        frac_nxt  = '0;
        dig_nxt   = '0;
      end else if (c != CH_CR && count_r < CNT_W'(LINE_MAX - 1)) begin
        count_nxt = count_r + 1'b1;
        if (!ended_r) begin
          if (c == CH_NUL) begin
            ended_nxt = 1'b1;
          end else begin
            for (int i = 0; i < HEAD_N; i++)
              if (count_r == CNT_W'(i)) head_nxt[i] = c;
            if (!colon_r && c == CH_COLON) begin
              colon_nxt = 1'b1;
              pos_nxt   = '0;
              lead0_nxt = '0;
              lead1_nxt = '0;
              phase_nxt = PH_BLANK;
              neg_nxt   = 1'b0;
              int_nxt   = '0;
              frac_nxt  = '0;
              dig_nxt   = '0;
            end else begin
              if (pos_r == 2'd0) begin
                lead0_nxt = c;
                p0        = c;
              end
              if (pos_r == 2'd1) lead1_nxt = c;
              if (pos_r != 2'd0 && (p0 == "S" || p0 == "T" || p0 == "A")) feed = 1'b1;
              if (pos_r >= 2'd2 && (p0 == "a" || p0 == "s" || p0 == "t")) feed = 1'b1;
              if (pos_r != 2'd3) pos_nxt = pos_r + 1'b1;
              if (feed) begin
                int_wide = 19'(int_r) * 19'd10 + 19'(d);
                case (phase_r)
                  PH_BLANK: begin
                    if (c == " " || c == "\t") begin
                      phase_nxt = PH_BLANK;
                    end else if (c == "-") begin
                      neg_nxt   = 1'b1;
                      phase_nxt = PH_INT;
                    end else if (c == "+") begin
                      phase_nxt = PH_INT;
                    end else if (is_digit(c)) begin
                      int_nxt   = (int_wide > 19'(INT_SAT)) ? INT_SAT : int_wide[INT_W-1:0];
                      phase_nxt = PH_INT;
                    end else if (c == ".") begin
                      phase_nxt = PH_FRAC;
                    end else begin
                      phase_nxt = PH_DONE;
                    end
                  end
                  PH_INT: begin
                    if (is_digit(c))
                      int_nxt = (int_wide > 19'(INT_SAT)) ? INT_SAT : int_wide[INT_W-1:0];
                    else if (c == ".")
                      phase_nxt = PH_FRAC;
                    else
                      phase_nxt = PH_DONE;
                  end
                  PH_FRAC: begin
                    if (is_digit(c)) begin
                      if (dig_r < 3'd4) begin
                        frac_nxt = frac_r + frac_weight(dig_r, d);
                        dig_nxt  = dig_r + 1'b1;
                      end
                    end else begin
                      phase_nxt = PH_DONE;
                    end
                  end
                  default: phase_nxt = phase_r;
                endcase
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    res_r  <= res_nxt;
    if (!rst_n) begin
      byte_v_r <= 1'b0;
      res_v_r  <= 1'b0;
      count_r  <= '0;
      ended_r  <= 1'b0;
      for (int i = 0; i < HEAD_N; i++) head_r[i] <= '0;
      colon_r  <= 1'b0;
      pos_r    <= '0;
      lead0_r  <= '0;
      lead1_r  <= '0;
      phase_r  <= PH_BLANK;
      neg_r    <= 1'b0;
      int_r    <= '0;
      frac_r   <= '0;
      dig_r    <= '0;
      mask_r   <= '0;
    end else begin
      byte_v_r <= byte_v_nxt;
      res_v_r  <= res_v_nxt;
      count_r  <= count_nxt;
      ended_r  <= ended_nxt;
      for (int i = 0; i < HEAD_N; i++) head_r[i] <= head_nxt[i];
      colon_r  <= colon_nxt;
      pos_r    <= pos_nxt;
      lead0_r  <= lead0_nxt;
      lead1_r  <= lead1_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      int_r    <= int_nxt;
      frac_r   <= frac_nxt;
      dig_r    <= dig_nxt;
      mask_r   <= mask_nxt;
    end
  end

  a_ended_needs_char: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> count_r != '0)
    else $error("line end marked with no character counted");

  a_frac_digits_cap: assert property (@(posedge clk) disable iff (!rst_n)
    dig_r <= 3'd4)
    else $error("fraction digit count above four");

  a_lf_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    byte_take && is_lf |=> res_v_r)
    else $error("line feed taken without a result");

endmodule

// ===== sv/wclp_fixed_out.sv =====
// Fraction scaling to Q15.16, sign, and the output register.
module wclp_fixed_out (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              res_valid,
  output logic                              res_ready,
  input  wclp_pkg::line_res_t               res,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wclp_pkg::KIND_W-1:0]       out_cmd_kind,
  output logic signed [wclp_pkg::VALUE_W-1:0] out_value,
  output logic [wclp_pkg::MASK_W-1:0]       out_client_mask
);
  import wclp_pkg::*;

  logic                   s2_v_r, s2_v_nxt;
  kind_t                  s2_kind_r;
  logic                   s2_neg_r;
  logic [INT_W-1:0]       s2_int_r;
  logic [MASK_W-1:0]      s2_mask_r;
  logic [Z_W-1:0]         s2_z_r;
  logic [FRAC_BITS-1:0]   s2_q0_r;

  logic                   o_v_r, o_v_nxt;
  kind_t                  o_kind_r;
  logic [VALUE_W-1:0]     o_value_r;
  logic [MASK_W-1:0]      o_mask_r;

  logic                   o_free, s2_free, s2_load, o_load;
  logic [Z_W-1:0]         z;
  logic [PROD_W-1:0]      prod;
  logic [Z_W-1:0]         rem;
  logic [FRAC_BITS-1:0]   q;
  logic [VALUE_W-1:0]     mag;

  assign o_free    = !o_v_r || out_ready;
  assign s2_free   = !s2_v_r || o_free;
  assign res_ready = s2_free;
  assign s2_load   = res_valid && s2_free;
  assign o_load    = s2_v_r && o_free;

  assign z    = {res.frac4, 12'd0} + Z_BIAS;
  assign prod = PROD_W'(z) * PROD_W'(RECIP);

  assign rem  = s2_z_r - Z_W'(Z_W'(s2_q0_r) * DIVISOR);
  assign q    = (rem >= DIVISOR) ? s2_q0_r + 1'b1 : s2_q0_r;
  assign mag  = {1'b0, s2_int_r, q};

  always_comb begin
    s2_v_nxt = s2_load || (s2_v_r && !o_free);
    o_v_nxt  = o_load || (o_v_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_kind_r <= res.kind;
      s2_neg_r  <= res.neg;
      s2_int_r  <= res.int_part;
      s2_mask_r <= res.mask;
      s2_z_r    <= z;
      s2_q0_r   <= prod[RECIP_SH +: FRAC_BITS];
    end
    if (o_load) begin
      o_kind_r  <= s2_kind_r;
      o_value_r <= s2_neg_r ? (VALUE_W'(0) - mag) : mag;
      o_mask_r  <= s2_mask_r;
    end
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  assign out_valid       = o_v_r;
  assign out_cmd_kind    = o_kind_r;
  assign out_value       = o_value_r;
  assign out_client_mask = o_mask_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> rem < (DIVISOR + DIVISOR))
    else $error("reciprocal estimate off by more than one");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && (o_kind_r == KIND_NONE || o_kind_r == KIND_STOP) |-> o_value_r == '0)
    else $error("nonzero value for none or stop");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    o_load |=> o_v_r)
    else $error("scaled word lost on its way to the output");

endmodule

// ===== verif/wifi_command_line_parser_top_tb.sv =====
// Self-checking testbench for the command line parser: directed and random byte lines.
module wifi_command_line_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wclp_pkg::*;

  typedef logic [7:0] octet_t;

  typedef struct {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic [MASK_W-1:0]  mask;
  } line_word_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_rx_byte = 8'h00;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [KIND_W-1:0]         out_cmd_kind;
  logic signed [VALUE_W-1:0] out_value;
  logic [MASK_W-1:0]         out_client_mask;

  bit          calm = 1'b0;
  int unsigned bytes_sent, lines_sent, words_checked, mismatches;
  line_word_t  due_lines[$];

  // shadow of the line parser
  int unsigned       ln_count;
  bit                ln_stopped;
  octet_t            head[HEAD_N];
  bit                colon_hit;
  int unsigned       pl_pos;
  octet_t            pl_lead[2];
  phase_t            num_phase = PH_BLANK;
  bit                num_neg;
  int unsigned       int_acc, frac_acc, frac_cnt;
  logic [MASK_W-1:0] clients = '0;

  wifi_command_line_parser_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cmd_kind    (out_cmd_kind),
    .out_value       (out_value),
    .out_client_mask (out_client_mask)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 37);
  end

  function automatic bit is_dec(input octet_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic void clear_payload();
    pl_pos     = 0;
    pl_lead[0] = '0;
    pl_lead[1] = '0;
    num_phase  = PH_BLANK;
    num_neg    = 1'b0;
    int_acc    = 0;
    frac_acc   = 0;
    frac_cnt   = 0;
  endfunction

  function automatic void clear_line();
    ln_count   = 0;
    ln_stopped = 1'b0;
    foreach (head[i]) head[i] = '0;
    colon_hit  = 1'b0;
    clear_payload();
  endfunction

  function automatic void add_int_digit(input octet_t c);
    int_acc = int_acc * 10 + (c - "0");
    if (int_acc > INT_SAT) int_acc = INT_SAT;
  endfunction

  function automatic void parse_byte(input octet_t c);
    int unsigned     idx;
    int              id;
    octet_t          p0, p1;
    bit              lead_num;
    longint unsigned f4, q;
    logic [31:0]     mag;
    line_word_t      w;
    if (c == CH_LF) begin
      if (is_dec(head[0]) && head[1] == ",") begin
        id = head[0] - "0";
        if (id < MAX_CLIENTS) begin
          if (head[2] == "C" && head[3] == "O" && head[4] == "N")
            clients = clients | MASK_W'(32'd1 << id);
          else if (head[2] == "C" && head[3] == "L")
            clients = clients & ~MASK_W'(32'd1 << id);
        end
      end
      p0 = pl_lead[0];
      p1 = pl_lead[1];
      lead_num = is_dec(p1) || p1 == "-" || p1 == "+" || p1 == ".";
      case (p0)
        "S":     w.kind = lead_num ? KIND_SPEED : KIND_NONE;
        "T":     w.kind = lead_num ? KIND_TURN : KIND_NONE;
        "A":     w.kind = lead_num ? KIND_ANGLE : KIND_NONE;
        "Z":     w.kind = KIND_STOP;
        "a":     w.kind = (p1 == "p") ? KIND_ANGLE_KP : (p1 == "d") ? KIND_ANGLE_KD : KIND_NONE;
        "s":     w.kind = (p1 == "p") ? KIND_SPEED_KP : (p1 == "i") ? KIND_SPEED_KI : KIND_NONE;
        "t":     w.kind = (p1 == "p") ? KIND_TURN_KP : (p1 == "d") ? KIND_TURN_KD : KIND_NONE;
        default: w.kind = KIND_NONE;
      endcase
      w.value = '0;
      if (w.kind != KIND_NONE && w.kind != KIND_STOP) begin
        f4 = frac_acc;
        repeat (4 - frac_cnt) f4 = f4 * 10;
        q = (f4 * 65536 + 5000) / 10000;
        mag = (int_acc << 16) + q[15:0];
        w.value = num_neg ? -mag : mag;
      end
      w.mask = clients;
      due_lines.push_back(w);
      clear_line();
      return;
    end
    if (c == CH_CR || ln_count >= LINE_MAX - 1) return;
    idx = ln_count;
    ln_count++;
    if (ln_stopped) return;
    if (c == CH_NUL) begin
      ln_stopped = 1'b1;
      return;
    end
    if (idx < HEAD_N) head[idx] = c;
    if (!colon_hit && c == CH_COLON) begin
      colon_hit = 1'b1;
      clear_payload();
      return;
    end
    if (pl_pos < 2) pl_lead[pl_pos] = c;
    p0 = pl_lead[0];
    if ((pl_pos >= 1 && (p0 == "S" || p0 == "T" || p0 == "A")) ||
        (pl_pos >= 2 && (p0 == "a" || p0 == "s" || p0 == "t"))) begin
      case (num_phase)
        PH_BLANK:
          if (c == "-") begin
            num_neg   = 1'b1;
            num_phase = PH_INT;
          end else if (c == "+") begin
            num_phase = PH_INT;
          end else if (is_dec(c)) begin
            add_int_digit(c);
            num_phase = PH_INT;
          end else if (c == ".") begin
            num_phase = PH_FRAC;
          end else if (c != " " && c != "\t") begin
            num_phase = PH_DONE;
          end
        PH_INT:
          if (is_dec(c)) add_int_digit(c);
          else if (c == ".") num_phase = PH_FRAC;
          else num_phase = PH_DONE;
        PH_FRAC:
          if (!is_dec(c)) begin
            num_phase = PH_DONE;
          end else if (frac_cnt < 4) begin
            frac_acc = frac_acc * 10 + (c - "0");
            frac_cnt++;
          end
        default: ;
      endcase
    end
    if (pl_pos < 3) pl_pos++;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 30) $display("MISMATCH at word %0d: %s", words_checked, msg);
  endtask

  always @(posedge clk) begin : check_output
    line_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (due_lines.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind=%0d value=%h mask=%b",
                                  out_cmd_kind, out_value, out_client_mask));
      end else begin
        want = due_lines.pop_front();
        if (out_cmd_kind !== want.kind)
          report_mismatch($sformatf("cmd_kind %0d, want %0d", out_cmd_kind, want.kind));
        if (out_value !== want.value)
          report_mismatch($sformatf("value %h, want %h", out_value, want.value));
        if (out_client_mask !== want.mask)
          report_mismatch($sformatf("client_mask %b, want %b", out_client_mask, want.mask));
      end
    end
  end

  task automatic send_byte(input octet_t b);
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_byte(b);
    bytes_sent++;
    if (b == CH_LF) lines_sent++;
  endtask

  task automatic send_octets(input octet_t seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  function automatic void add_text(ref octet_t seq[$], input string s);
    for (int i = 0; i < s.len(); i++) seq.push_back(s[i]);
  endfunction

  task automatic send_line(input string s);
    octet_t seq[$];
    add_text(seq, s);
    seq.push_back(CH_LF);
    send_octets(seq);
  endtask

  function automatic void build_command(ref octet_t seq[$]);
    string tokens[10] = '{"S", "T", "A", "Z", "ap", "ad", "sp", "si", "tp", "td"};
    int    sel;
    sel = $urandom_range(0, 9);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        add_text(seq, "+IPD,");
        seq.push_back(octet_t'("0" + $urandom_range(0, 4)));
        add_text(seq, ",12:");
      end
      3: begin
        repeat ($urandom_range(0, 4)) seq.push_back(octet_t'($urandom_range(33, 126)));
        seq.push_back(CH_COLON);
      end
      default: ;
    endcase
    add_text(seq, tokens[sel]);
    if (sel > 3 || $urandom_range(0, 9) == 0)
      repeat ($urandom_range(0, 2)) seq.push_back($urandom_range(0, 1) ? " " : "\t");
    case ($urandom_range(0, 3))
      1: seq.push_back("-");
      2: seq.push_back("+");
      default: ;
    endcase
    repeat ($urandom_range(0, 6)) seq.push_back(octet_t'("0" + $urandom_range(0, 9)));
    if ($urandom_range(0, 1)) begin
      seq.push_back(".");
      repeat ($urandom_range(0, 6)) seq.push_back(octet_t'("0" + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) seq.push_back(octet_t'($urandom_range(32, 126)));
  endfunction

  task automatic test_commands();
    send_line("S100");
    send_line("T-25.5");
    send_line("A+.5");
    send_line("Z");
    send_line("ap 1.25");
    send_line("ad\t-3");
    send_line("sp7");
    send_line("si0.0001");
    send_line("tp  12.34567");
    send_line("td-0");
    send_line("X12");
    send_line("S");
    send_line("Sx");
    send_line("a");
    send_line("+IPD,0,6:A-7.25");
  endtask

  task automatic test_number_edges();
    send_line("S99999");
    send_line("T-32767.99999");
    send_line("A.");
    send_line("S-");
    send_line("S1.99995");
    send_line("S0.5");
    send_line("sp\t \t+3.14159x9");
    send_line("Z12");
    send_line("S3.2.1");
  endtask

  task automatic test_client_events();
    send_line("0,CONNECT");
    send_line("4,CONNECT");
    send_line("2,CONNECT");
    send_line("5,CONNECT");
    send_line("9,CONNECT");
    send_line("2,CLOSED");
    send_line("4,CL");
    send_line("1;CONNECT");
    send_line("3,CON:S5");
  endtask

  task automatic test_line_edges();
    octet_t seq[$];
    send_line("S1\r2\r");
    add_text(seq, "S12");
    seq.push_back(CH_NUL);
    add_text(seq, "34");
    seq.push_back(CH_LF);
    send_octets(seq);
    seq = {};
    add_text(seq, "S1");
    repeat (60) seq.push_back("7");
    seq.push_back(CH_LF);
    send_octets(seq);
    seq = {};
    add_text(seq, "Z");
    repeat (50) seq.push_back("0");
    add_text(seq, ":S5");
    seq.push_back(CH_LF);
    send_octets(seq);
    send_line("");
    send_line("\r");
    seq = '{8'hFF, 8'h80, 8'h7F, 8'h01, CH_NUL, CH_LF};
    send_octets(seq);
    send_line("ab:cd:S5");
    send_line("x:ap:3");
  endtask

  task automatic test_random_lines();
    octet_t      seq[$];
    int unsigned first, pick;
    first = bytes_sent;
    while (bytes_sent < first + 700) begin
      calm = (bytes_sent - first >= 220) && (bytes_sent - first < 470);
      seq = {};
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        build_command(seq);
      end else if (pick < 75) begin
        if ($urandom_range(0, 9) == 0) seq.push_back(octet_t'($urandom_range(0, 255)));
        else seq.push_back(octet_t'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) != 0) seq.push_back(",");
        case ($urandom_range(0, 5))
          0: add_text(seq, "CONNECT");
          1: add_text(seq, "CLOSED");
          2: add_text(seq, "CON");
          3: add_text(seq, "CL");
          4: add_text(seq, "CX");
          default: add_text(seq, "CONNECT FAIL:T-2.5");
        endcase
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 12)) seq.push_back(octet_t'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        if ($urandom_range(0, 1)) add_text(seq, "S-1.5");
        repeat ($urandom_range(40, 70)) seq.push_back(octet_t'($urandom_range(32, 126)));
      end else begin
        build_command(seq);
        if ($urandom_range(0, 1)) begin
          seq.insert($urandom_range(0, seq.size()), CH_NUL);
        end else begin
          repeat ($urandom_range(1, 3)) if (seq.size() > 0) void'(seq.pop_back());
        end
      end
      if ($urandom_range(0, 9) == 0) seq.insert($urandom_range(0, seq.size()), CH_CR);
      seq.push_back(CH_LF);
      send_octets(seq);
    end
    calm = 1'b0;
  endtask

  initial begin
    clear_line();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands();
    test_number_edges();
    test_client_events();
    test_line_edges();
    test_random_lines();
    in_valid <= 1'b0;
    for (int n = 0; n < 5000 && due_lines.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (due_lines.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", due_lines.size()));
    $display("Sent %0d bytes in %0d lines: all commands, number edges, client events,",
             bytes_sent, lines_sent);
    $display("CR, zero byte and overlong lines; %0d words compared, %0d mismatches",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
